// ----- hw/rtl/drl_pkg.sv -----
package drl_pkg;

  localparam int COORD_BITS = 12;
  localparam int CFG_W      = 12;
  localparam int CFG_ADDR_W = 2;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FULL_REFRESH  = 2'd2;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_RECT = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_STORED       = 3'd0,
    ST_COVERED      = 3'd1,
    ST_EMPTY        = 3'd2,
    ST_FULL_REFRESH = 3'd3,
    ST_LIST_FULL    = 3'd4,
    ST_FADING       = 3'd5
  } status_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] l;
    logic [COORD_BITS-1:0] t;
    logic [COORD_BITS-1:0] r;
    logic [COORD_BITS-1:0] b;
  } box_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             full;
  } cfg_t;

  // decoded request, edges already clipped
  typedef struct packed {
    logic is_flush;
    logic fading;
    logic empty;
    box_t box;
  } req_t;

  typedef struct packed {
    kind_t   kind;
    status_t status;
    box_t    box;
    logic    last;
  } res_t;

  function automatic logic [COORD_BITS-1:0] clamp(input logic [COORD_BITS-1:0] v,
                                                  input logic [COORD_BITS-1:0] hi);
    logic [COORD_BITS-1:0] mag;
    mag = {1'b0, v[COORD_BITS-2:0]};
    if (v[COORD_BITS-1]) begin
      return '0;
    end else if (mag > hi) begin
      return hi;
    end
    return mag;
  endfunction

  function automatic logic holds(input box_t outer, input box_t inner);
    return (outer.l <= inner.l) && (inner.r <= outer.r) &&
           (outer.t <= inner.t) && (inner.b <= outer.b);
  endfunction

endpackage

// ----- hw/rtl/drl_store.sv -----
module drl_store #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/drl_ctrl.sv -----
module drl_ctrl #(
  parameter int MAX_RECTS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  drl_pkg::cfg_t  cfg,
  input  logic           req_valid,
  input  drl_pkg::req_t  req,
  output logic           req_ready,
  output logic           res_valid,
  input  logic           res_ready,
  output drl_pkg::res_t  res_out
);

  localparam int IW = $clog2(MAX_RECTS);
  localparam int CW = $clog2(MAX_RECTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FINISH,
    S_FLUSH,
    S_RESULT
  } state_t;

  state_t           state;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    j;
  logic [CW-1:0]    keep;
  logic [CW-1:0]    flush_n;
  logic             covered;
  logic             fading;
  drl_pkg::box_t    nb;
  drl_pkg::res_t    pend;

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  drl_pkg::box_t    mem_wdata;
  logic             mem_re;
  logic [IW-1:0]    mem_raddr;
  drl_pkg::box_t    entry;

  logic             accept;
  logic             start_walk;
  logic             start_flush;
  logic             cover_hit;
  logic             keep_this;
  logic [CW-1:0]    keep_next;
  logic [CW-1:0]    j_inc;
  logic             walk_end;
  logic             flush_last;
  logic             out_free;
  logic             load_out;
  logic             append;

  drl_store #(
    .DEPTH(MAX_RECTS),
    .WIDTH($bits(drl_pkg::box_t))
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(entry)
  );

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign out_free   = !res_valid || res_ready;
  assign load_out   = ((state == S_FLUSH) || (state == S_RESULT)) && out_free;
  assign j_inc      = j + CW'(1);
  assign walk_end   = (j_inc == cnt);
  assign flush_last = (j_inc == flush_n);

  assign start_walk  = accept && !req.is_flush && !cfg.full && !req.empty && (cnt != '0);
  assign start_flush = accept && req.is_flush && !cfg.full && !req.fading && (cnt != '0);

  // first containing entry stops removals; it and everything after it stay
  assign cover_hit = !covered && drl_pkg::holds(entry, nb);
  assign keep_this = covered || cover_hit || !drl_pkg::holds(nb, entry);
  assign keep_next = keep + CW'(keep_this);

  assign append = (state == S_FINISH) && !covered && !fading && (cnt != CW'(MAX_RECTS));

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = keep[IW-1:0];
    mem_wdata = entry;
    if (start_walk || start_flush) begin
      mem_re = 1'b1;
    end
    if (state == S_WALK) begin
      mem_we = keep_this;
      if (!walk_end) begin
        mem_re    = 1'b1;
        mem_raddr = j_inc[IW-1:0];
      end
    end
    if (state == S_FLUSH && out_free && !flush_last) begin
      mem_re    = 1'b1;
      mem_raddr = j_inc[IW-1:0];
    end
    if (append) begin
      mem_we    = 1'b1;
      mem_waddr = cnt[IW-1:0];
      mem_wdata = nb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend.last   <= 1'b1;
            nb          <= req.box;
            fading      <= req.fading;
            covered     <= 1'b0;
            keep        <= '0;
            j           <= '0;
            flush_n     <= cnt;
            if (req.is_flush == drl_pkg::REQ_ADD) begin
              pend.kind <= drl_pkg::KIND_ADD;
              pend.box  <= '0;
              if (cfg.full) begin
                pend.status <= drl_pkg::ST_FULL_REFRESH;
                state       <= S_RESULT;
              end else if (req.empty) begin
                pend.status <= drl_pkg::ST_EMPTY;
                state       <= S_RESULT;
              end else if (cnt == '0) begin
                state <= S_FINISH;
              end else begin
                state <= S_WALK;
              end
            end else begin
              cnt         <= '0;
              pend.status <= drl_pkg::ST_STORED;
              if (cfg.full) begin
                pend.kind <= drl_pkg::KIND_RECT;
                pend.box  <= '{l: '0, t: '0, r: cfg.width, b: cfg.height};
                state     <= S_RESULT;
              end else if (cnt == '0 || req.fading) begin
                pend.kind <= drl_pkg::KIND_NONE;
                pend.box  <= '0;
                state     <= S_RESULT;
              end else begin
                state <= S_FLUSH;
              end
            end
          end
        end
        S_WALK: begin
          keep    <= keep_next;
          covered <= covered || cover_hit;
          j       <= j_inc;
          if (walk_end) begin
            cnt   <= keep_next;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (covered) begin
            pend.status <= drl_pkg::ST_COVERED;
          end else if (fading) begin
            pend.status <= drl_pkg::ST_FADING;
          end else if (cnt == CW'(MAX_RECTS)) begin
            pend.status <= drl_pkg::ST_LIST_FULL;
          end else begin
            pend.status <= drl_pkg::ST_STORED;
            cnt         <= cnt + CW'(1);
          end
          state <= S_RESULT;
        end
        S_FLUSH: begin
          if (out_free) begin
            res_out.kind   <= drl_pkg::KIND_RECT;
            res_out.status <= drl_pkg::ST_STORED;
            res_out.box    <= entry;
            res_out.last   <= flush_last;
            j              <= j_inc;
            if (flush_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            res_out <= pend;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/dirty_rect_list.sv -----
// Dirty rectangle list.
// Input stream s_*: s_tuser is the request type (add or flush); s_tdata carries
// the rectangle edges and the fading flag. An add returns one status result;
// a flush returns each stored rectangle in order (tlast on the final one), or a
// single whole-screen or nothing-to-copy result.
// Output stream m_*: m_tuser is the result kind, m_tlast marks the final
// result of a request.
// Config: cfg_we/cfg_addr/cfg_data write screen_width (0), screen_height (1)
// and full_refresh_mode (2); write only while the block is idle.
// An add of a non-empty box with full-refresh mode off walks the stored entries
// in order: the walk reads one entry of the list memory per cycle and writes
// back the kept ones at the same time. A flush that returns stored rectangles
// reads them out through the registered memory read, one per cycle while the
// receiver takes them.
// One request is in work at a time; s_tready rises again once the last result
// has been loaded into the output register.
// A stalled receiver holds the output register and pauses the flush readout.
// Reset empties the list (the memory itself is not cleared) and loads
// 320 x 200 with full-refresh mode on.
module dirty_rect_list #(
  parameter int MAX_RECTS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // rect_left, rect_top, rect_right, rect_bottom, fading_out, zero pad
  input  logic [drl_pkg::IN_DATA_W-1:0]      s_tdata,
  // req_type
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // add_status, out_left, out_top, out_right, out_bottom, zero pad
  output logic [drl_pkg::OUT_DATA_W-1:0]     m_tdata,
  // result_kind
  output logic [1:0]                         m_tuser,
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [drl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [drl_pkg::CFG_W-1:0]          cfg_data
);

  localparam int CB = drl_pkg::COORD_BITS;

  drl_pkg::cfg_t cfg;
  drl_pkg::req_t req;
  drl_pkg::box_t clipped;
  drl_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= drl_pkg::CFG_W'(320);
      cfg.height <= drl_pkg::CFG_W'(200);
      cfg.full   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        drl_pkg::REG_SCREEN_WIDTH:  cfg.width  <= cfg_data;
        drl_pkg::REG_SCREEN_HEIGHT: cfg.height <= cfg_data;
        drl_pkg::REG_FULL_REFRESH:  cfg.full   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    clipped.l    = drl_pkg::clamp(s_tdata[CB-1:0],        cfg.width);
    clipped.t    = drl_pkg::clamp(s_tdata[2*CB-1:CB],     cfg.height);
    clipped.r    = drl_pkg::clamp(s_tdata[3*CB-1:2*CB],   cfg.width);
    clipped.b    = drl_pkg::clamp(s_tdata[4*CB-1:3*CB],   cfg.height);
    req.is_flush = s_tuser;
    req.fading   = s_tdata[4*CB];
    req.box      = clipped;
    req.empty    = (clipped.l >= clipped.r) || (clipped.t >= clipped.b);
  end

  drl_ctrl #(
    .MAX_RECTS(MAX_RECTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req_valid(s_tvalid),
    .req      (req),
    .req_ready(s_tready),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res_out  (res)
  );

  assign m_tuser = res.kind;
  assign m_tlast = res.last;
  assign m_tdata = {(drl_pkg::OUT_DATA_W - 3 - 4*CB)'(0),
                    res.box.b, res.box.r, res.box.t, res.box.l, res.status};

`ifndef SYNTHESIS
  a_add_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == drl_pkg::KIND_ADD) |-> m_tlast)
    else $error("add result without tlast");

  a_flush_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != drl_pkg::KIND_ADD) |-> (m_tdata[2:0] == drl_pkg::ST_STORED))
    else $error("flush result with nonzero status");

  a_none_no_edges: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == drl_pkg::KIND_NONE) |-> (m_tdata[50:3] == '0) && m_tlast)
    else $error("nothing-to-copy result carries edges");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");
`endif

endmodule

// ----- tb/dirty_rect_list_tb.sv -----
module dirty_rect_list_tb;

  localparam int SLOTS      = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_AT    = 45;
  localparam int HOLD_LEN   = 400;
  localparam int CALM_LO    = 150;
  localparam int CALM_HI    = 200;
  localparam int TAIL_WAIT  = 40;

  typedef struct {
    logic        req;
    logic [11:0] l, t, r, b;
    logic        fade;
  } req_item_t;

  typedef struct {
    int l, t, r, b;
  } area_t;

  typedef struct {
    drl_pkg::kind_t   kind;
    drl_pkg::status_t st;
    logic [11:0]      l, t, r, b;
    logic             last;
  } result_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [drl_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [drl_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [1:0]                     m_tuser;
  logic                           m_tlast;
  logic                           cfg_we;
  logic [drl_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [drl_pkg::CFG_W-1:0]      cfg_data;

  dirty_rect_list dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  // shadow of the block's registers and list
  int        scr_w = 320;
  int        scr_h = 200;
  bit        refresh_on = 1'b1;
  area_t     dirty[$];

  req_item_t pending[$];
  result_t   expected[$];

  int queued;
  int in_count;
  int out_count;
  int flush_count;
  int fails;
  int idle_cycles;
  int status_seen[6];
  bit took_in;
  int hold_left;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clip_edge(input logic [11:0] raw, input int hi);
    int v;
    v = $signed(raw);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit encloses(input area_t o, input area_t i);
    return o.l <= i.l && i.r <= o.r && o.t <= i.t && i.b <= o.b;
  endfunction

  function automatic result_t make_result(input drl_pkg::kind_t k, input drl_pkg::status_t s,
                                          input area_t a, input logic last);
    result_t res;
    res.kind = k;
    res.st   = s;
    res.l    = 12'(a.l);
    res.t    = 12'(a.t);
    res.r    = 12'(a.r);
    res.b    = 12'(a.b);
    res.last = last;
    return res;
  endfunction

  function automatic int fit(input int v);
    return v > 2047 ? 2047 : v;
  endfunction

  function automatic bit calm();
    return in_count >= CALM_LO && in_count < CALM_HI;
  endfunction

  // works out the results of one accepted request and updates the shadow list
  task automatic predict_request(input req_item_t q);
    area_t            nb;
    area_t            zero;
    area_t            whole;
    area_t            kept[$];
    drl_pkg::status_t st;
    bit               covered;
    zero = '{0, 0, 0, 0};
    if (q.req == drl_pkg::REQ_ADD) begin
      if (refresh_on) begin
        st = drl_pkg::ST_FULL_REFRESH;
      end else begin
        nb.l = clip_edge(q.l, scr_w);
        nb.t = clip_edge(q.t, scr_h);
        nb.r = clip_edge(q.r, scr_w);
        nb.b = clip_edge(q.b, scr_h);
        if (nb.l >= nb.r || nb.t >= nb.b) begin
          st = drl_pkg::ST_EMPTY;
        end else begin
          // once a covering entry is met, it and everything after it stay
          covered = 1'b0;
          foreach (dirty[i]) begin
            if (!covered && encloses(dirty[i], nb)) covered = 1'b1;
            if (covered || !encloses(nb, dirty[i])) kept.insert(kept.size(), dirty[i]);
          end
          dirty = kept;
          if (covered) begin
            st = drl_pkg::ST_COVERED;
          end else if (q.fade) begin
            st = drl_pkg::ST_FADING;
          end else if (dirty.size() >= SLOTS) begin
            st = drl_pkg::ST_LIST_FULL;
          end else begin
            dirty.insert(dirty.size(), nb);
            st = drl_pkg::ST_STORED;
          end
        end
      end
      status_seen[int'(st)]++;
      expected.insert(expected.size(), make_result(drl_pkg::KIND_ADD, st, zero, 1'b1));
    end else begin
      flush_count++;
      // status field reads zero on every flush result
      if (refresh_on) begin
        whole = '{0, 0, scr_w, scr_h};
        expected.insert(expected.size(),
                        make_result(drl_pkg::KIND_RECT, drl_pkg::ST_STORED, whole, 1'b1));
      end else if (dirty.size() == 0 || q.fade) begin
        expected.insert(expected.size(),
                        make_result(drl_pkg::KIND_NONE, drl_pkg::ST_STORED, zero, 1'b1));
      end else begin
        foreach (dirty[i])
          expected.insert(expected.size(),
                          make_result(drl_pkg::KIND_RECT, drl_pkg::ST_STORED, dirty[i],
                                      i == dirty.size() - 1));
      end
      dirty.delete();
    end
  endtask

  // input acceptance, result checking and watchdog
  always @(posedge clk) begin
    result_t want;
    bit      bad;
    took_in = !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (took_in) begin
        predict_request(pending.pop_front());
        in_count++;
      end
      if (m_tvalid && m_tready) begin
        out_count++;
        if (expected.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result %0d: kind %0d data %h last %0d",
                     out_count, m_tuser, m_tdata, m_tlast);
        end else begin
          want = expected.pop_front();
          bad = m_tuser != want.kind || m_tdata[2:0] != want.st ||
                m_tdata[14:3] != want.l || m_tdata[26:15] != want.t ||
                m_tdata[38:27] != want.r || m_tdata[50:39] != want.b ||
                m_tlast != want.last;
          if (bad) begin
            fails++;
            if (fails <= 10) begin
              $display("result %0d: expected kind %0d status %0d box %0d,%0d,%0d,%0d last %0d",
                       out_count, want.kind, want.st, want.l, want.t, want.r, want.b,
                       want.last);
              $display("result %0d:      got kind %0d status %0d box %0d,%0d,%0d,%0d last %0d",
                       out_count, m_tuser, m_tdata[2:0], m_tdata[14:3], m_tdata[26:15],
                       m_tdata[38:27], m_tdata[50:39], m_tlast);
            end
          end
        end
      end
      if (took_in || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                   idle_cycles, expected.size());
          $display("dirty_rect_list verification failed");
          $finish;
        end
      end
    end
  end

  // request driver: an offer stays up until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !took_in) begin
      s_tvalid <= 1'b1;
    end else if (pending.size() > 0 && (calm() || $urandom_range(99) >= 20)) begin
      s_tvalid <= 1'b1;
      s_tuser  <= pending[0].req;
      s_tdata  <= {7'b0, pending[0].fade, pending[0].b, pending[0].r, pending[0].t,
                   pending[0].l};
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && in_count >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) m_tready <= 1'b0;
      else if (calm()) m_tready <= 1'b1;
      else m_tready <= $urandom_range(99) >= 20;
    end
  end

  task automatic push_add(input int l, input int t, input int r, input int b,
                          input bit fade);
    req_item_t q;
    q.req  = drl_pkg::REQ_ADD;
    q.l    = 12'(l);
    q.t    = 12'(t);
    q.r    = 12'(r);
    q.b    = 12'(b);
    q.fade = fade;
    pending.insert(pending.size(), q);
    queued++;
  endtask

  task automatic push_flush(input bit fade);
    req_item_t q;
    q.req  = drl_pkg::REQ_FLUSH;
    q.l    = 12'($urandom);
    q.t    = 12'($urandom);
    q.r    = 12'($urandom);
    q.b    = 12'($urandom);
    q.fade = fade;
    pending.insert(pending.size(), q);
    queued++;
  endtask

  task automatic add_rand_box(input bit fade);
    int l, t, sw, sh;
    l  = $urandom_range(scr_w + 8) - 8;
    t  = $urandom_range(scr_h + 8) - 8;
    sw = $urandom_range(3) == 0 ? $urandom_range(scr_w) : $urandom_range(scr_w / 4 + 1);
    sh = $urandom_range(3) == 0 ? $urandom_range(scr_h) : $urandom_range(scr_h / 4 + 1);
    push_add(fit(l), fit(t), fit(l + sw), fit(t + sh), fade);
  endtask

  // more disjoint tiles than the list holds, then a flush of a full list
  task automatic grid_burst();
    int cw, ch, k;
    cw = scr_w / 8;
    ch = scr_h / 5;
    k  = $urandom_range(SLOTS + 1, SLOTS + 4);
    for (int i = 0; i < k; i++)
      push_add((i % 8) * cw, (i / 8) * ch, fit((i % 8) * cw + cw), fit((i / 8) * ch + ch),
               1'b0);
    push_flush(1'b0);
  endtask

  task automatic write_reg(input logic [drl_pkg::CFG_ADDR_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= 12'(val);
  endtask

  task automatic drain();
    while (pending.size() > 0 || expected.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int w, input int h, input bit full, input int quota,
                           input bit grid_first);
    int start, pick, ox, oy, ow, oh, ix, iy;
    write_reg(drl_pkg::REG_SCREEN_WIDTH, w);
    write_reg(drl_pkg::REG_SCREEN_HEIGHT, h);
    write_reg(drl_pkg::REG_FULL_REFRESH, full);
    @(negedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
    refresh_on = full;
    start = queued;
    if (grid_first) grid_burst();
    while (queued - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 12 && scr_w >= 8 && scr_h >= 5) begin
        grid_burst();
      end else if (pick < 30) begin
        // boxes inside one outer box; the outer one comes last, and sometimes first as well
        ox = $urandom_range(scr_w / 2);
        oy = $urandom_range(scr_h / 2);
        ow = $urandom_range(1, scr_w - ox);
        oh = $urandom_range(1, scr_h - oy);
        if ($urandom_range(1)) push_add(ox, oy, fit(ox + ow), fit(oy + oh), 1'b0);
        repeat ($urandom_range(1, 4)) begin
          ix = ox + $urandom_range(ow - 1);
          iy = oy + $urandom_range(oh - 1);
          push_add(ix, iy, fit(ix + $urandom_range(1, ox + ow - ix)),
                   fit(iy + $urandom_range(1, oy + oh - iy)), 1'b0);
        end
        push_add(ox, oy, fit(ox + ow), fit(oy + oh), $urandom_range(4) == 0);
        push_flush(1'b0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) add_rand_box($urandom_range(9) == 0);
        push_flush($urandom_range(9) == 0);
      end else begin
        // raw field values, any bit pattern
        repeat (4) begin
          if ($urandom_range(4) == 0) push_flush($urandom_range(1));
          else push_add($urandom, $urandom, $urandom, $urandom, $urandom_range(1));
        end
      end
    end
    drain();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    m_tready = 1'b0;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: full refresh, adds ignored
    push_add(10, 10, 50, 50, 1'b0);
    push_add(10, 10, 50, 50, 1'b1);
    push_flush(1'b0);
    push_flush(1'b1);
    drain();

    write_reg(drl_pkg::REG_FULL_REFRESH, 0);
    @(negedge clk);
    cfg_we <= 1'b0;
    refresh_on = 1'b0;
    push_flush(1'b0);                              // empty list
    push_add(50, 50, 10, 80, 1'b0);                // inverted
    push_add(10, 30, 40, 30, 1'b0);                // zero height
    push_add(-2048, -2048, -1, -1, 1'b0);          // all off screen, negative
    push_add(400, 10, 2047, 50, 1'b0);             // all off screen, right
    push_add(-2048, -2048, 2047, 2047, 1'b0);      // clips to whole screen
    push_add(10, 10, 20, 20, 1'b0);                // covered
    push_flush(1'b0);
    push_add(10, 10, 20, 20, 1'b0);
    push_add(30, 30, 60, 60, 1'b0);
    push_add(100, 0, 120, 10, 1'b0);
    push_add(5, 5, 70, 70, 1'b0);                  // swallows first two
    push_add(110, 2, 115, 8, 1'b0);                // covered by the first stored entry
    push_add(0, 0, 200, 100, 1'b1);                // fading: removes, no store
    push_add(300, 180, 330, 210, 1'b0);            // clipped at bottom right
    push_add(1, 1, 2, 2, 1'b0);
    push_flush(1'b1);                              // fading flush still clears
    push_flush(1'b0);
    push_add(0, 0, 1, 1, 1'b0);
    push_add(-5, 190, 5, 205, 1'b0);
    push_flush(1'b0);
    drain();

    run_phase(2048, 2048, 1'b0, 30, 1'b0);
    run_phase(1, 1, 1'b0, 30, 1'b0);
    run_phase(640, 480, 1'b0, 30, 1'b1);
    run_phase(2048, 1, 1'b0, 30, 1'b0);
    run_phase(100, 60, 1'b1, 30, 1'b0);
    run_phase(16, 8, 1'b0, 30, 1'b1);
    run_phase($urandom_range(1, 2048), $urandom_range(1, 2048), 1'b0, 30, 1'b0);

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    $display("Ran %0d requests (%0d flushes) over 9 screen settings, %0d results checked.",
             in_count, flush_count, out_count);
    $display("Adds: stored %0d covered %0d empty %0d refresh %0d list-full %0d fading %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (fails == 0 && expected.size() == 0) begin
      $display("dirty_rect_list verification clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fails, expected.size());
      $display("dirty_rect_list verification failed");
    end
    $finish;
  end

endmodule
